@@ sv/postfix_expression_evaluator_macros.svh @@
// Assertion helpers for the postfix expression evaluator.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PEE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define PEE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/pee_pkg.sv @@
package pee_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int DATA_W          = 32;
   localparam int DIV_STEPS       = 32;
   localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef logic [4:0] step_type;

   localparam step_type ST_IDLE   = 5'd0;
   localparam step_type ST_DECODE = 5'd1;
   localparam step_type ST_NUMEND = 5'd2;
   localparam step_type ST_POPB   = 5'd3;
   localparam step_type ST_LDB    = 5'd4;
   localparam step_type ST_POPA   = 5'd5;
   localparam step_type ST_LDA    = 5'd6;
   localparam step_type ST_EXEC   = 5'd7;
   localparam step_type ST_PUSHR  = 5'd8;
   localparam step_type ST_DIVI   = 5'd9;
   localparam step_type ST_DIVS   = 5'd10;
   localparam step_type ST_DIVE   = 5'd11;
   localparam step_type ST_CHK    = 5'd12;
   localparam step_type ST_FIN    = 5'd13;
   localparam step_type ST_FPOP   = 5'd14;
   localparam step_type ST_OWAIT  = 5'd15;
   localparam step_type ST_OUT    = 5'd16;

   typedef enum logic [3:0] {
      ACT_NOP      = 4'd0,
      ACT_TAKE     = 4'd1,
      ACT_DIGIT    = 4'd2,
      ACT_PUSH_ACC = 4'd3,
      ACT_POP      = 4'd4,
      ACT_LD_B     = 4'd5,
      ACT_LD_A     = 4'd6,
      ACT_EXEC     = 4'd7,
      ACT_PUSH_R   = 4'd8,
      ACT_DIV_INIT = 4'd9,
      ACT_DIV_STEP = 4'd10,
      ACT_DIV_END  = 4'd11,
      ACT_LD_OUT   = 4'd12
   } act_type;

   typedef enum logic [2:0] {
      CND_NEVER    = 3'd0,
      CND_ALWAYS   = 3'd1,
      CND_NO_REQ   = 3'd2,
      CND_IS_DIGIT = 3'd3,
      CND_NOT_OP   = 3'd4,
      CND_IS_DIV   = 3'd5,
      CND_DIV_MORE = 3'd6,
      CND_NOT_LAST = 3'd7
   } cnd_type;

   // Output busy is tested through its own flag in the datapath, see ST_OWAIT.
   typedef struct packed {
      act_type  act;
      cnd_type  cnd;
      logic     wait_out;
      step_type target;
   } ctl_type;

   function automatic ctl_type ucode(input step_type s);
      ctl_type w;
      w = '{act: ACT_NOP, cnd: CND_NEVER, wait_out: 1'b0, target: ST_IDLE};
      case (s)
         ST_IDLE:   w = '{ACT_TAKE,     CND_NO_REQ,   1'b0, ST_IDLE};
         ST_DECODE: w = '{ACT_DIGIT,    CND_IS_DIGIT, 1'b0, ST_CHK};
         ST_NUMEND: w = '{ACT_PUSH_ACC, CND_NOT_OP,   1'b0, ST_CHK};
         ST_POPB:   w = '{ACT_POP,      CND_NEVER,    1'b0, ST_IDLE};
         ST_LDB:    w = '{ACT_LD_B,     CND_NEVER,    1'b0, ST_IDLE};
         ST_POPA:   w = '{ACT_POP,      CND_NEVER,    1'b0, ST_IDLE};
         ST_LDA:    w = '{ACT_LD_A,     CND_NEVER,    1'b0, ST_IDLE};
         ST_EXEC:   w = '{ACT_EXEC,     CND_IS_DIV,   1'b0, ST_DIVI};
         ST_PUSHR:  w = '{ACT_PUSH_R,   CND_ALWAYS,   1'b0, ST_CHK};
         ST_DIVI:   w = '{ACT_DIV_INIT, CND_NEVER,    1'b0, ST_IDLE};
         ST_DIVS:   w = '{ACT_DIV_STEP, CND_DIV_MORE, 1'b0, ST_DIVS};
         ST_DIVE:   w = '{ACT_DIV_END,  CND_ALWAYS,   1'b0, ST_PUSHR};
         ST_CHK:    w = '{ACT_NOP,      CND_NOT_LAST, 1'b0, ST_IDLE};
         ST_FIN:    w = '{ACT_PUSH_ACC, CND_NEVER,    1'b0, ST_IDLE};
         ST_FPOP:   w = '{ACT_POP,      CND_NEVER,    1'b0, ST_IDLE};
         ST_OWAIT:  w = '{ACT_NOP,      CND_NEVER,    1'b1, ST_OWAIT};
         ST_OUT:    w = '{ACT_LD_OUT,   CND_ALWAYS,   1'b0, ST_IDLE};
         default:   w = '{ACT_NOP,      CND_ALWAYS,   1'b0, ST_IDLE};
      endcase
      return w;
   endfunction

endpackage

@@ sv/postfix_expression_evaluator.sv @@
// Postfix expression evaluator.
// req channel: one ASCII character a beat (req_ch) with req_last on the final
// one. Digits build a number; + - * / pop b then a and push a op b (32-bit
// wrap, division truncates toward zero); any other character ends a number.
// rsp channel: one beat per expression, after the beat marked last: popped top
// value (-1 if empty) and sticky underflow, overflow and divide-by-zero flags.
// Control: a microprogram runs each character from a control ROM; a beat is
// taken only while the sequencer sits in its idle step. A digit is decoded and
// checked; other characters push the open number, and + - * / then pop b and a,
// execute (/ in the one-bit-a-cycle restoring divider) and push. A last beat
// pushes any open number and pops the top before the result is registered on rsp.
// The result sits in an output register, so the next expression is taken while
// it waits; only a second result stalls the sequencer until rsp_stall drops.
// Reset clears the sequencer, stack level, number and flags; the stack memory
// itself is not cleared, as only entries below the level are ever used. After
// each result the evaluator returns to that cleared state.
`include "postfix_expression_evaluator_macros.svh"

module postfix_expression_evaluator #(
   parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_ch,
   input  logic                             req_last,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [pee_pkg::DATA_W-1:0] rsp_value,
   output logic                             rsp_underflow,
   output logic                             rsp_overflow,
   output logic                             rsp_div_zero
);
   import pee_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int LW = $clog2(STACK_DEPTH + 1);

   logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

   step_type          upc_ff, upc_in;
   logic [7:0]        ch_ff, ch_in;
   logic              last_ff, last_in;
   logic [LW-1:0]     level_ff, level_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              in_num_ff, in_num_in;
   logic              under_ff, under_in;
   logic              over_ff, over_in;
   logic              dz_flag_ff, dz_flag_in;
   logic              pop_empty_ff, pop_empty_in;
   logic [DATA_W-1:0] rd_data_ff;
   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic [DATA_W-1:0] r_ff, r_in;
   logic [DATA_W-1:0] dq_ff, dq_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] ub_ff, ub_in;
   logic              neg_ff, neg_in;
   logic              dz_ff, dz_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_under_ff, rsp_under_in;
   logic              rsp_over_ff, rsp_over_in;
   logic              rsp_dz_ff, rsp_dz_in;

   ctl_type           ctl;
   logic              is_digit, is_op, cond_hit, out_busy;
   logic [7:0]        digit_full;
   logic [3:0]        digit;
   logic              push_req, stack_full;
   logic [DATA_W-1:0] push_data;
   logic [LW-1:0]     level_m1;
   logic [AW-1:0]     rd_addr;
   logic [DATA_W-1:0] popped;
   logic [DATA_W:0]   rem_sh, rem_diff;

   assign ctl = ucode(upc_ff);

   always_comb begin
      is_digit = ch_ff inside {[CH_ZERO:CH_NINE]};
      case (ch_ff) inside
         CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: is_op = 1'b1;
         default:                              is_op = 1'b0;
      endcase
   end

   assign digit_full = ch_ff - CH_ZERO;
   assign digit      = digit_full[3:0];
   assign out_busy   = rsp_valid_ff && rsp_stall;
   assign stack_full = level_ff == LW'(STACK_DEPTH);
   assign level_m1   = level_ff - 1'b1;
   assign rd_addr    = (level_ff == '0) ? '0 : level_m1[AW-1:0];
   assign popped     = pop_empty_ff ? '1 : rd_data_ff;
   assign push_req   = (ctl.act == ACT_PUSH_ACC && in_num_ff) || ctl.act == ACT_PUSH_R;
   assign push_data  = (ctl.act == ACT_PUSH_R) ? r_ff : acc_ff;
   assign rem_sh     = {rem_ff, dq_ff[DATA_W-1]};
   assign rem_diff   = rem_sh - {1'b0, ub_ff};

   // Jump decision of the sequencer.
   always_comb begin
      case (ctl.cnd)
         CND_NEVER:    cond_hit = 1'b0;
         CND_ALWAYS:   cond_hit = 1'b1;
         CND_NO_REQ:   cond_hit = !req_valid;
         CND_IS_DIGIT: cond_hit = is_digit;
         CND_NOT_OP:   cond_hit = !is_op;
         CND_IS_DIV:   cond_hit = ch_ff == CH_SLASH;
         CND_DIV_MORE: cond_hit = cnt_ff != DIV_CNT_W'(DIV_STEPS - 1);
         CND_NOT_LAST: cond_hit = !last_ff;
         default:      cond_hit = 1'b0;
      endcase
      if (ctl.wait_out && out_busy) begin
         upc_in = ctl.target;
      end else if (!ctl.wait_out && cond_hit) begin
         upc_in = ctl.target;
      end else begin
         upc_in = upc_ff + 1'b1;
      end
   end

   assign req_stall = ctl.act != ACT_TAKE;

   always_comb begin
      ch_in        = ch_ff;
      last_in      = last_ff;
      level_in     = level_ff;
      acc_in       = acc_ff;
      in_num_in    = in_num_ff;
      under_in     = under_ff;
      over_in      = over_ff;
      dz_flag_in   = dz_flag_ff;
      pop_empty_in = pop_empty_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      r_in         = r_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      ub_in        = ub_ff;
      neg_in       = neg_ff;
      dz_in        = dz_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_under_in = rsp_under_ff;
      rsp_over_in  = rsp_over_ff;
      rsp_dz_in    = rsp_dz_ff;

      if (push_req) begin
         if (stack_full) begin
            over_in = 1'b1;
         end else begin
            level_in = level_ff + 1'b1;
         end
      end

      case (ctl.act)
         ACT_TAKE: begin
            if (req_valid) begin
               ch_in   = req_ch;
               last_in = req_last;
            end
         end
         ACT_DIGIT: begin
            if (is_digit) begin
               acc_in    = {acc_ff[DATA_W-4:0], 3'b000} + {acc_ff[DATA_W-2:0], 1'b0}
                         + {{(DATA_W-4){1'b0}}, digit};
               in_num_in = 1'b1;
            end
         end
         ACT_PUSH_ACC: begin
            acc_in    = '0;
            in_num_in = 1'b0;
         end
         ACT_POP: begin
            if (level_ff == '0) begin
               pop_empty_in = 1'b1;
               under_in     = 1'b1;
            end else begin
               pop_empty_in = 1'b0;
               level_in     = level_m1;
            end
         end
         ACT_LD_B: b_in = popped;
         ACT_LD_A: a_in = popped;
         ACT_EXEC: begin
            case (ch_ff)
               CH_PLUS:  r_in = a_ff + b_ff;
               CH_MINUS: r_in = a_ff - b_ff;
               default:  r_in = a_ff * b_ff;
            endcase
         end
         ACT_DIV_INIT: begin
            dq_in  = a_ff[DATA_W-1] ? -a_ff : a_ff;
            ub_in  = b_ff[DATA_W-1] ? -b_ff : b_ff;
            rem_in = '0;
            cnt_in = '0;
            neg_in = a_ff[DATA_W-1] ^ b_ff[DATA_W-1];
            dz_in  = b_ff == '0;
            if (b_ff == '0) begin
               dz_flag_in = 1'b1;
            end
         end
         ACT_DIV_STEP: begin
            // Restoring step: one quotient bit a cycle.
            if (!rem_diff[DATA_W]) begin
               rem_in = rem_diff[DATA_W-1:0];
               dq_in  = {dq_ff[DATA_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[DATA_W-1:0];
               dq_in  = {dq_ff[DATA_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
         end
         ACT_DIV_END: begin
            if (dz_ff) begin
               r_in = '0;
            end else begin
               r_in = neg_ff ? -dq_ff : dq_ff;
            end
         end
         ACT_LD_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = popped;
            rsp_under_in = under_ff;
            rsp_over_in  = over_ff;
            rsp_dz_in    = dz_flag_ff;
            // Drop what is left of this expression.
            level_in     = '0;
            acc_in       = '0;
            in_num_in    = 1'b0;
            under_in     = 1'b0;
            over_in      = 1'b0;
            dz_flag_in   = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (push_req && !stack_full) begin
         stack_mem[level_ff[AW-1:0]] <= push_data;
      end
      // Hold the popped word until it is used; the final pop may wait on rsp.
      if (ctl.act == ACT_POP) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= ST_IDLE;
         level_ff     <= '0;
         acc_ff       <= '0;
         in_num_ff    <= 1'b0;
         under_ff     <= 1'b0;
         over_ff      <= 1'b0;
         dz_flag_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         level_ff     <= level_in;
         acc_ff       <= acc_in;
         in_num_ff    <= in_num_in;
         under_ff     <= under_in;
         over_ff      <= over_in;
         dz_flag_ff   <= dz_flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff        <= ch_in;
      last_ff      <= last_in;
      pop_empty_ff <= pop_empty_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      r_ff         <= r_in;
      dq_ff        <= dq_in;
      rem_ff       <= rem_in;
      ub_ff        <= ub_in;
      neg_ff       <= neg_in;
      dz_ff        <= dz_in;
      cnt_ff       <= cnt_in;
      rsp_value_ff <= rsp_value_in;
      rsp_under_ff <= rsp_under_in;
      rsp_over_ff  <= rsp_over_in;
      rsp_dz_ff    <= rsp_dz_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_underflow = rsp_under_ff;
   assign rsp_overflow  = rsp_over_ff;
   assign rsp_div_zero  = rsp_dz_ff;

   `PEE_ASSERT_NOW(a_level_bound, 1'b1, level_ff <= LW'(STACK_DEPTH), "stack level beyond depth")
   `PEE_ASSERT_NEXT(a_take_decode, req_valid && !req_stall, upc_ff == ST_DECODE, "beat not decoded")
   `PEE_ASSERT_NOW(a_no_overwrite, ctl.act == ACT_LD_OUT, !out_busy, "result overwritten")
   `PEE_ASSERT_NOW(a_div_full, upc_ff == ST_DIVE, $past(upc_ff) == ST_DIVS, "divider cut short")

endmodule

@@ sim/tb_top.sv @@
module tb_top;
   import pee_pkg::*;

   localparam int          DEPTH      = STACK_DEPTH_DEF;
   localparam int          IDLE_LIMIT = 4000;
   localparam int          TOTAL_BEATS = 1400;
   localparam logic [7:0]  CH_SPACE   = 8'h20;
   localparam logic [7:0]  CH_NEWLINE = 8'h0A;

   typedef struct {
      logic [7:0] ch;
      logic       last;
      bit         hold;
   } char_beat_type;

   typedef struct packed {
      logic [31:0] value;
      logic        underflow;
      logic        overflow;
      logic        div_zero;
   } eval_result_type;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch    = 8'h00;
   logic        req_last  = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_value;
   logic        rsp_underflow;
   logic        rsp_overflow;
   logic        rsp_div_zero;

   char_beat_type   char_beats[$];
   eval_result_type expected_results[$];
   logic [7:0]      expr_buf[$];
   int unsigned     mismatches = 0;

   // evaluator shadow state
   logic [31:0] calc_stack[DEPTH];
   int unsigned calc_level = 0;
   logic [31:0] num_acc    = '0;
   bit          num_open   = 1'b0;
   bit          flag_under = 1'b0;
   bit          flag_over  = 1'b0;
   bit          flag_div0  = 1'b0;

   bit tx_calm = 1'b0;
   bit rx_calm = 1'b0;

   postfix_expression_evaluator dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ch        (req_ch),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value     (rsp_value),
      .rsp_underflow (rsp_underflow),
      .rsp_overflow  (rsp_overflow),
      .rsp_div_zero  (rsp_div_zero)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit is_token(logic [7:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
             c == CH_STAR || c == CH_SLASH;
   endfunction

   function automatic void stack_push(logic [31:0] v);
      if (calc_level >= DEPTH) begin
         flag_over = 1'b1;
      end else begin
         calc_stack[calc_level] = v;
         calc_level++;
      end
   endfunction

   function automatic logic [31:0] stack_pop();
      if (calc_level == 0) begin
         flag_under = 1'b1;
         return '1;
      end
      calc_level--;
      return calc_stack[calc_level];
   endfunction

   function automatic logic [31:0] divide_trunc(logic [31:0] a, logic [31:0] b);
      longint sa;
      longint sb;
      longint q;
      sa = $signed(a);
      sb = $signed(b);
      if (sb == 0) begin
         flag_div0 = 1'b1;
         return '0;
      end
      q = sa / sb;
      return q[31:0];
   endfunction

   function automatic void close_number();
      if (num_open) begin
         stack_push(num_acc);
         num_acc  = '0;
         num_open = 1'b0;
      end
   endfunction

   function automatic void clear_state();
      calc_level = 0;
      num_acc    = '0;
      num_open   = 1'b0;
      flag_under = 1'b0;
      flag_over  = 1'b0;
      flag_div0  = 1'b0;
   endfunction

   function automatic void evaluate_char(logic [7:0] c, logic fin);
      logic [31:0]     a;
      logic [31:0]     b;
      logic [31:0]     r;
      eval_result_type res;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         num_acc  = num_acc * 10 + 32'(c - CH_ZERO);
         num_open = 1'b1;
      end else begin
         close_number();
         if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
            b = stack_pop();
            a = stack_pop();
            case (c)
               CH_PLUS:  r = a + b;
               CH_MINUS: r = a - b;
               CH_STAR:  r = a * b;
               default:  r = divide_trunc(a, b);
            endcase
            stack_push(r);
         end
      end
      if (fin) begin
         close_number();
         res.value     = stack_pop();
         res.underflow = flag_under;
         res.overflow  = flag_over;
         res.div_zero  = flag_div0;
         expected_results.push_back(res);
         clear_state();
      end
   endfunction

   function automatic int unsigned draw_wait(bit calm);
      return calm ? 0 : $urandom_range(0, 6);
   endfunction

   // stimulus building

   function automatic logic [7:0] pick_op();
      case ($urandom_range(0, 3))
         0:       return CH_PLUS;
         1:       return CH_MINUS;
         2:       return CH_STAR;
         default: return CH_SLASH;
      endcase
   endfunction

   function automatic logic [7:0] pick_separator();
      logic [7:0] c;
      case ($urandom_range(0, 4))
         0, 1, 2: return CH_SPACE;
         3:       return CH_NEWLINE;
         default: begin
            do c = 8'($urandom_range(0, 255)); while (is_token(c));
            return c;
         end
      endcase
   endfunction

   function automatic void put_number();
      int unsigned len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
      for (int i = 0; i < len; i++)
         expr_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
   endfunction

   function automatic void put_wellformed(int unsigned ops, int unsigned max_depth, bit greedy);
      int unsigned depth = 0;
      int unsigned done  = 0;
      bit          prev_num = 1'b0;
      while (done < ops || depth != 1) begin
         if (depth < 2 || (done < ops && depth < max_depth &&
                           (greedy || $urandom_range(0, 1) == 1))) begin
            if (prev_num)
               expr_buf.push_back(pick_separator());
            put_number();
            depth++;
            prev_num = 1'b1;
         end else begin
            if (prev_num && $urandom_range(0, 1) == 1)
               expr_buf.push_back(pick_separator());
            expr_buf.push_back(pick_op());
            depth--;
            done++;
            prev_num = 1'b0;
         end
      end
      if ($urandom_range(0, 2) == 0)
         expr_buf.push_back(pick_separator());
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++)
         expr_buf.push_back(s[i]);
   endfunction

   // move the built expression into the send queue, last flag on its final beat
   function automatic void commit_expression(bit hold);
      char_beat_type b;
      for (int i = 0; i < expr_buf.size(); i++) begin
         b.ch   = expr_buf[i];
         b.last = (i == expr_buf.size() - 1);
         b.hold = hold && (i == 0);
         char_beats.push_back(b);
      end
      expr_buf.delete();
   endfunction

   task automatic fill_stimulus();
      int unsigned sel;
      int unsigned n_expr = 0;
      int unsigned len;
      int unsigned r;
      // NUL alone: empty stack on the final pop
      expr_buf.push_back(8'h00);
      commit_expression(1'b0);
      // top code as a separator
      expr_buf.push_back(8'hFF);
      add_text("5");
      commit_expression(1'b0);
      // all four operators, negative quotient truncating toward zero
      add_text("3 4+2*5-0 7-/");
      commit_expression(1'b0);
      add_text("8 0/");
      commit_expression(1'b0);
      // accumulator wraps past 32 bits
      add_text("9999999999");
      commit_expression(1'b0);

      while (char_beats.size() < TOTAL_BEATS) begin
         sel = $urandom_range(0, 99);
         if (sel < 70) begin
            put_wellformed($urandom_range(0, 8), $urandom_range(2, 6), 1'b0);
         end else if (sel < 80) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
               r = $urandom_range(0, 9);
               if (r < 4)
                  expr_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
               else if (r < 7)
                  expr_buf.push_back(pick_op());
               else
                  expr_buf.push_back(8'($urandom_range(0, 255)));
            end
         end else if (sel < 90) begin
            put_wellformed($urandom_range(1, 6), $urandom_range(2, 5), 1'b0);
            if ($urandom_range(0, 1) == 1)
               expr_buf.delete($urandom_range(0, expr_buf.size() - 1));
            else
               expr_buf.insert($urandom_range(0, expr_buf.size()), pick_op());
            if (expr_buf.size() == 0)
               expr_buf.push_back(pick_op());
         end else if (sel < 95) begin
            // most negative value over minus one
            add_text("0 2147483648-0 1-/");
         end else begin
            put_wellformed($urandom_range(15, 22), $urandom_range(15, 20), 1'b1);
         end
         commit_expression(n_expr % 40 == 0);
         n_expr++;
      end
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
   endtask

   // driver
   int unsigned gap_left = 0;

   always @(posedge clock) begin : drive
      logic          nv;
      char_beat_type nb;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         nv = req_valid;
         if (req_valid && !req_stall) begin
            evaluate_char(req_ch, req_last);
            nv = 1'b0;
         end
         if (!nv) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (char_beats.size() != 0 &&
                         !(char_beats[0].hold && expected_results.size() != 0)) begin
               nb = char_beats.pop_front();
               req_ch   <= nb.ch;
               req_last <= nb.last;
               nv = 1'b1;
               if ($urandom_range(0, 39) == 0)
                  tx_calm = !tx_calm;
               gap_left = draw_wait(tx_calm);
            end
         end
         req_valid <= nv;
      end
   end

   // monitor
   int unsigned stall_left = 0;

   always @(posedge clock) begin : watch_rsp
      eval_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_value, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_value !== want.value)
                  report_mismatch("value", rsp_value, want.value);
               if (rsp_underflow !== want.underflow)
                  report_mismatch("underflow", 32'(rsp_underflow), 32'(want.underflow));
               if (rsp_overflow !== want.overflow)
                  report_mismatch("overflow", 32'(rsp_overflow), 32'(want.overflow));
               if (rsp_div_zero !== want.div_zero)
                  report_mismatch("div_zero", 32'(rsp_div_zero), 32'(want.div_zero));
            end
            if ($urandom_range(0, 9) == 0)
               rx_calm = !rx_calm;
            stall_left = draw_wait(rx_calm);
         end else if (rsp_valid && rsp_stall && stall_left > 0) begin
            stall_left--;
         end
         // hold stall while a drawn wait is still owed to a valid beat
         rsp_stall <= (stall_left > 0);
      end
   end

   // watchdog
   int unsigned idle_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      clear_state();
      fill_stimulus();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (char_beats.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      // let a late division or a stray beat show up
      repeat (100) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
